### rtl/brb_pkg.sv
`timescale 1ns / 1ps
// brb_pkg: constants, operation codes and result type for the byte ring buffer.
// No dependencies.
package brb_pkg;

   localparam int DEPTH    = 1024;
   localparam int READ_MAX = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = 11;
   localparam int RD_W     = $clog2(READ_MAX + 1);
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 2;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 24;

   localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_ERASE_HEAD = 2'd2;
   localparam logic [OP_W-1:0] OP_ERASE_TAIL = 2'd3;

   typedef struct packed {
      logic              last;
      logic [CNT_W-1:0]  amount;
      logic              valid;
      logic [BYTE_W-1:0] data;
   } rsp_type;

endpackage

### rtl/brb_ram.sv
`timescale 1ns / 1ps
// brb_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module brb_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/byte_ring_buffer.sv
`timescale 1ns / 1ps
// byte_ring_buffer: circular byte FIFO with run-time capacity, message writes,
// bounded reads and head/tail erase. Uses brb_pkg and brb_ram.
// Throughput: one write or erase word per cycle while the result queue has room; a read
// of n bytes streams one byte per cycle from the storage RAM read port while the queue has
// room, and holds off new requests until its last byte has been read from the RAM.
// Reset (synchronous): buffer empty, capacity DEPTH; storage contents not cleared.
module byte_ring_buffer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [brb_pkg::REQ_W-1:0] req_tdata,  // count[10:0], data_in[18:11]
   input  logic [brb_pkg::OP_W-1:0]  req_tuser,  // op[1:0]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [brb_pkg::RSP_W-1:0] rsp_tdata,  // data_out[7:0], amount[18:8]
   output logic                      rsp_tuser,  // data_valid
   output logic                      rsp_tlast,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [brb_pkg::CNT_W-1:0] csr_data
);
   import brb_pkg::*;

   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] pos,
                                                  input logic [CNT_W-1:0]  off,
                                                  input logic [CNT_W-1:0]  cap);
      logic [CNT_W:0] s;
      s = {{(CNT_W + 1 - ADDR_W){1'b0}}, pos} + {1'b0, off};
      if (s >= {1'b0, cap}) begin
         s = s - {1'b0, cap};
      end
      return s[ADDR_W-1:0];
   endfunction

   logic [CNT_W-1:0]  cap_ff, cap_in, cap_eff;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  wleft_ff, wleft_in;
   logic              wacc_ff, wacc_in;
   logic [RD_W-1:0]   rd_left_ff, rd_left_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  rd_amt_ff, rd_amt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rd_last_ff, rd_last_in;
   logic [1:0]        occ_ff, occ_in;
   rsp_type           q_ff [2];
   rsp_type           q_in [2];

   logic [OP_W-1:0]   op;
   logic [CNT_W-1:0]  count;
   logic [BYTE_W-1:0] data_in;
   logic              accept, cfg_wr, pop, push, avail, busy, issue;
   rsp_type           push_word, op_word;
   logic              op_push;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] ram_q;
   logic [CNT_W-1:0]  wl_eff, n_rd, min_cf;
   logic              wa_eff, stored;
   logic [CNT_W:0]    ptr_nxt;

   assign op      = req_tuser;
   assign count   = req_tdata[CNT_W-1:0];
   assign data_in = req_tdata[CNT_W +: BYTE_W];

   assign cap_eff = (cap_ff == '0) ? CNT_W'(1) :
                    (cap_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_ff;

   assign busy       = (rd_left_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign avail      = ({1'b0, occ_ff} + {2'b00, rd_vld_ff}) < (3'd2 + {2'b00, pop});
   assign issue      = busy && avail;
   assign req_tready = !busy && !rd_vld_ff && avail;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign cfg_wr     = csr_valid && csr_ready;

   assign min_cf = (count < fill_ff) ? count : fill_ff;
   assign n_rd   = (min_cf > CNT_W'(READ_MAX)) ? CNT_W'(READ_MAX) : min_cf;
   assign ptr_nxt = {{(CNT_W + 1 - ADDR_W){1'b0}}, rd_ptr_ff} + 1'b1;
   assign wr_addr = wrap_add(head_ff, fill_ff, cap_eff);

   always_comb begin
      cap_in     = cap_ff;
      head_in    = head_ff;
      fill_in    = fill_ff;
      wleft_in   = wleft_ff;
      wacc_in    = wacc_ff;
      rd_left_in = rd_left_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_amt_in  = rd_amt_ff;
      rd_vld_in  = 1'b0;
      rd_last_in = 1'b0;
      op_push    = 1'b0;
      op_word    = '{last: 1'b1, amount: '0, valid: 1'b0, data: '0};
      wr_en      = 1'b0;
      wl_eff     = wleft_ff;
      wa_eff     = wacc_ff;
      stored     = 1'b0;

      if (issue) begin
         rd_left_in = rd_left_ff - 1'b1;
         rd_ptr_in  = (ptr_nxt == {1'b0, cap_eff}) ? '0 : ptr_nxt[ADDR_W-1:0];
         rd_vld_in  = 1'b1;
         rd_last_in = (rd_left_ff == RD_W'(1));
      end

      if (accept) begin
         if (op != OP_WRITE) begin
            wleft_in = '0;
            wacc_in  = 1'b0;
         end
         unique case (op)
            OP_WRITE: begin
               op_push = 1'b1;
               if (wleft_ff == '0) begin
                  wl_eff = count;
                  wa_eff = (count <= cap_eff - fill_ff);
               end
               if (wl_eff != '0) begin
                  stored   = wa_eff && (fill_ff < cap_eff);
                  wr_en    = stored;
                  fill_in  = fill_ff + CNT_W'(stored);
                  wleft_in = wl_eff - 1'b1;
                  wacc_in  = (wl_eff == CNT_W'(1)) ? 1'b0 : wa_eff;
                  op_word.amount = CNT_W'(stored);
               end
            end
            OP_READ: begin
               if (count == '0 || fill_ff == '0) begin
                  op_push = 1'b1;
               end else begin
                  rd_left_in = n_rd[RD_W-1:0];
                  rd_ptr_in  = head_ff;
                  rd_amt_in  = n_rd;
                  fill_in    = fill_ff - n_rd;
                  head_in    = (fill_ff == n_rd) ? '0 : wrap_add(head_ff, n_rd, cap_eff);
               end
            end
            OP_ERASE_HEAD, OP_ERASE_TAIL: begin
               op_push = 1'b1;
               if (count != '0) begin
                  if (count >= fill_ff) begin
                     op_word.amount = fill_ff;
                     head_in        = '0;
                     fill_in        = '0;
                  end else begin
                     op_word.amount = count;
                     fill_in        = fill_ff - count;
                     if (op == OP_ERASE_HEAD) begin
                        head_in = wrap_add(head_ff, count, cap_eff);
                     end
                  end
               end
            end
            default: begin
               op_push = 1'b0;
            end
         endcase
      end

      if (cfg_wr) begin
         cap_in   = csr_data;
         head_in  = '0;
         fill_in  = '0;
         wleft_in = '0;
         wacc_in  = 1'b0;
      end
   end

   // output queue, two words deep
   assign push      = rd_vld_ff || op_push;
   assign push_word = rd_vld_ff ?
                      '{last: rd_last_ff, amount: rd_amt_ff, valid: 1'b1, data: ram_q} :
                      op_word;

   always_comb begin
      occ_in  = occ_ff;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      priority if (pop && !push) begin
         q_in[0] = q_ff[1];
         occ_in  = occ_ff - 1'b1;
      end else if (push && !pop) begin
         if (occ_ff == 2'd0) begin
            q_in[0] = push_word;
         end else begin
            q_in[1] = push_word;
         end
         occ_in = occ_ff + 1'b1;
      end else if (push && pop) begin
         if (occ_ff == 2'd1) begin
            q_in[0] = push_word;
         end else begin
            q_in[0] = q_ff[1];
            q_in[1] = push_word;
         end
      end
   end

   assign rsp_tvalid = (occ_ff != 2'd0);
   assign rsp_tdata  = {{(RSP_W - CNT_W - BYTE_W){1'b0}}, q_ff[0].amount, q_ff[0].data};
   assign rsp_tuser  = q_ff[0].valid;
   assign rsp_tlast  = q_ff[0].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CNT_W'(DEPTH);
         head_ff    <= '0;
         fill_ff    <= '0;
         wleft_ff   <= '0;
         wacc_ff    <= 1'b0;
         rd_left_ff <= '0;
         rd_vld_ff  <= 1'b0;
         occ_ff     <= '0;
      end else begin
         cap_ff     <= cap_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         wleft_ff   <= wleft_in;
         wacc_ff    <= wacc_in;
         rd_left_ff <= rd_left_in;
         rd_vld_ff  <= rd_vld_in;
         occ_ff     <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      rd_amt_ff  <= rd_amt_in;
      rd_last_ff <= rd_last_in;
      q_ff[0]    <= q_in[0];
      q_ff[1]    <= q_in[1];
   end

   brb_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (BYTE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (data_in),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

endmodule

### rtl/brb_checker.sv
`timescale 1ns / 1ps
// brb_checker: port-level assertions for byte_ring_buffer, bound to the top level.
// Uses brb_pkg.
module brb_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [brb_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      rsp_tlast
);
   import brb_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[BYTE_W-1:0] == '0))
      else $error("status word not last or carries data");

   a_read_amount: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[BYTE_W +: CNT_W] != '0) &&
                                  (rsp_tdata[BYTE_W +: CNT_W] <= CNT_W'(READ_MAX)))
      else $error("read amount out of range");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### test/byte_ring_buffer_tb.sv
`timescale 1ns / 1ps
// byte_ring_buffer_tb: self-checking bench for the byte ring buffer. A directed table, then
// random message writes, reads and erases over several capacities, all scored by a predictor.
// Depends on brb_pkg and the byte_ring_buffer RTL.
module byte_ring_buffer_tb;
   import brb_pkg::*;

   typedef struct packed {
      logic             is_cfg;
      logic [OP_W-1:0]  op;
      logic [CNT_W-1:0] count;
      logic [7:0]       din;
      logic             typed;
      logic [CNT_W-1:0] amt;
   } plan_row_type;

   // count holds the capacity on configuration rows
   localparam int PLAN_N = 30;
   localparam plan_row_type PLAN [0:PLAN_N-1] = '{
      '{1'b0, OP_READ,       11'd5,    8'h00, 1'b1, 11'd0},
      '{1'b0, OP_ERASE_HEAD, 11'd3,    8'h00, 1'b1, 11'd0},
      '{1'b0, OP_ERASE_TAIL, 11'd0,    8'h00, 1'b1, 11'd0},
      '{1'b0, OP_WRITE,      11'd0,    8'hFF, 1'b1, 11'd0},
      '{1'b0, OP_WRITE,      11'd1024, 8'h5A, 1'b1, 11'd1},
      '{1'b0, OP_READ,       11'd1024, 8'h00, 1'b0, 11'd0},
      '{1'b1, OP_WRITE,      11'd3,    8'h00, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd4,    8'h00, 1'b1, 11'd0},
      '{1'b0, OP_WRITE,      11'd4,    8'hFF, 1'b1, 11'd0},
      '{1'b0, OP_WRITE,      11'd4,    8'hAA, 1'b1, 11'd0},
      '{1'b0, OP_WRITE,      11'd4,    8'h55, 1'b1, 11'd0},
      '{1'b0, OP_WRITE,      11'd3,    8'hFF, 1'b1, 11'd1},
      '{1'b0, OP_WRITE,      11'd3,    8'h80, 1'b1, 11'd1},
      '{1'b0, OP_WRITE,      11'd3,    8'h01, 1'b1, 11'd1},
      '{1'b0, OP_READ,       11'd0,    8'h00, 1'b1, 11'd0},
      '{1'b0, OP_READ,       11'd1024, 8'h00, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd2,    8'h12, 1'b1, 11'd1},
      '{1'b0, OP_ERASE_TAIL, 11'd1,    8'h00, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd3,    8'hA5, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd3,    8'h5A, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd3,    8'hC3, 1'b0, 11'd0},
      '{1'b0, OP_ERASE_HEAD, 11'd1,    8'h00, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd1,    8'h0F, 1'b0, 11'd0},
      '{1'b0, OP_READ,       11'd2,    8'h00, 1'b0, 11'd0},
      '{1'b1, OP_WRITE,      11'd0,    8'h00, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd1,    8'h99, 1'b0, 11'd0},
      '{1'b0, OP_WRITE,      11'd1,    8'h66, 1'b0, 11'd0},
      '{1'b0, OP_READ,       11'd64,   8'h00, 1'b0, 11'd0},
      '{1'b1, OP_WRITE,      11'd2047, 8'h00, 1'b0, 11'd0},
      '{1'b0, OP_ERASE_TAIL, 11'd1024, 8'h00, 1'b0, 11'd0}
   };

   localparam int RAND_PHASES = 6;
   localparam int PHASE_WORDS = 64;
   localparam logic [CNT_W-1:0] CAP_PLAN [0:RAND_PHASES-1] = '{
      11'd5, 11'd37, 11'd300, 11'd1, 11'd1024, 11'd64
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;   // count[10:0], data_in[18:11]
   logic [OP_W-1:0]   req_tuser = '0;   // op[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;        // data_out[7:0], amount[18:8]
   logic              rsp_tuser;        // data_valid
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_data = '0;

   byte_ring_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]       ring_mem [0:DEPTH-1];
   int unsigned      head_q;
   int unsigned      fill_q;
   int unsigned      msg_left;
   bit               msg_ok;
   logic [CNT_W-1:0] cap_reg = CNT_W'(DEPTH);

   rsp_type pending_rsp [$];
   int      n_err = 0;
   int      words_sent = 0;
   int      rsp_seen = 0;
   int      cfg_writes = 0;
   int      burst_left = 0;
   int      cyc_n = 0;

   function automatic int unsigned cap_eff();
      int unsigned c;
      c = 32'(cap_reg);
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic int unsigned ring_idx(int unsigned pos, int unsigned off, int unsigned cap);
      int unsigned s;
      s = (pos % cap) + (off % cap);
      if (s >= cap) s -= cap;
      return s;
   endfunction

   task automatic push_rsp(input logic [7:0] d, input bit v, input int unsigned amt, input bit l);
      rsp_type r;
      r.data   = d;
      r.valid  = v;
      r.amount = amt[CNT_W-1:0];
      r.last   = l;
      pending_rsp.push_back(r);
   endtask

   task automatic ring_predict(input logic [OP_W-1:0] op, input int unsigned cnt,
                               input logic [7:0] din);
      int unsigned cap;
      int unsigned n;
      bit          stored;
      cap = cap_eff();
      if (fill_q > cap) fill_q = cap;
      if (op == OP_WRITE) begin
         stored = 1'b0;
         if (msg_left == 0) begin
            if (cnt == 0) begin
               push_rsp(8'h00, 1'b0, 0, 1'b1);
               return;
            end
            msg_ok   = (cnt <= cap - fill_q);
            msg_left = cnt;
         end
         if (msg_ok && fill_q < cap) begin
            ring_mem[ring_idx(head_q, fill_q, cap)] = din;
            fill_q++;
            stored = 1'b1;
         end
         msg_left--;
         if (msg_left == 0) msg_ok = 1'b0;
         push_rsp(8'h00, 1'b0, 32'(stored), 1'b1);
         return;
      end
      // any other op abandons a partial message
      msg_left = 0;
      msg_ok   = 1'b0;
      if (op == OP_READ) begin
         if (cnt == 0 || fill_q == 0) begin
            push_rsp(8'h00, 1'b0, 0, 1'b1);
            return;
         end
         n = (cnt < fill_q) ? cnt : fill_q;
         if (n > READ_MAX) n = READ_MAX;
         for (int unsigned i = 0; i < n; i++)
            push_rsp(ring_mem[ring_idx(head_q, i, cap)], 1'b1, n, (i + 1 == n));
         fill_q -= n;
         head_q = (fill_q == 0) ? 0 : ring_idx(head_q, n, cap);
         return;
      end
      n = 0;
      if (cnt != 0) begin
         if (cnt >= fill_q) begin
            n      = fill_q;
            head_q = 0;
            fill_q = 0;
         end else begin
            n = cnt;
            if (op == OP_ERASE_HEAD) head_q = ring_idx(head_q, cnt, cap);
            fill_q -= cnt;
         end
      end
      push_rsp(8'h00, 1'b0, n, 1'b1);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      n_err++;
   endtask

   // sender works in bursts with random gaps
   task automatic push_word(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] cnt,
                            input logic [7:0] din, input bit typed,
                            input logic [CNT_W-1:0] typed_amt);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, din, cnt};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      words_sent++;
      ring_predict(op, 32'(cnt), din);
      if (typed) begin
         void'(pending_rsp.pop_back());
         push_rsp(8'h00, 1'b0, 32'(typed_amt), 1'b1);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CNT_W-1:0] value);
      wait_idle();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_reg  = value;
      head_q   = 0;
      fill_q   = 0;
      msg_left = 0;
      msg_ok   = 1'b0;
      cfg_writes++;
   endtask

   // receiver stall pattern cycles through four modes
   always @(posedge clock) begin
      cyc_n <= cyc_n + 1;
      case (cyc_n[10:9])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 9) < 7);
         2'd2: rsp_tready <= (cyc_n % 3 == 0);
         default: rsp_tready <= ($urandom_range(0, 9) < 4);
      endcase
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("response word with nothing pending, data",
                            int'(rsp_tdata[7:0]), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[7:0] !== want.data)
               report_mismatch("data_out", int'(rsp_tdata[7:0]), int'(want.data));
            if (rsp_tuser !== want.valid)
               report_mismatch("data_valid", int'(rsp_tuser), int'(want.valid));
            if (rsp_tdata[18:8] !== want.amount)
               report_mismatch("amount", int'(rsp_tdata[18:8]), int'(want.amount));
            if (rsp_tlast !== want.last)
               report_mismatch("last", int'(rsp_tlast), int'(want.last));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int          pick;
      int          len;
      int          nsend;
      int          start;
      int unsigned free;
      head_q   = 0;
      fill_q   = 0;
      msg_left = 0;
      msg_ok   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PLAN_N; r++) begin
         if (PLAN[r].is_cfg)
            set_capacity(PLAN[r].count);
         else
            push_word(PLAN[r].op, PLAN[r].count, PLAN[r].din, PLAN[r].typed, PLAN[r].amt);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         set_capacity(CAP_PLAN[p]);
         start = words_sent;
         while (words_sent - start < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               free = cap_eff() - fill_q;
               pick = $urandom_range(0, 99);
               if (pick < 3)
                  len = 0;
               else if (pick < 12) begin
                  len = free + $urandom_range(1, 8);
                  if (len > DEPTH) len = DEPTH;
               end else if (free == 0)
                  len = $urandom_range(1, 4);
               else
                  len = $urandom_range(1, (free < 24) ? free : 24);
               nsend = (len == 0) ? 1 : len;
               if (nsend > 24) nsend = $urandom_range(1, 24);
               // cut some messages short
               if (nsend > 1 && $urandom_range(0, 9) == 0) nsend = $urandom_range(1, nsend - 1);
               for (int k = 0; k < nsend; k++)
                  push_word(OP_WRITE, CNT_W'(len), 8'($urandom_range(0, 255)), 1'b0, '0);
            end else if (pick < 80) begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1024) : $urandom_range(1, 40);
               push_word(OP_READ, CNT_W'(len), 8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
               len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 12);
               push_word((pick < 90) ? OP_ERASE_HEAD : OP_ERASE_TAIL, CNT_W'(len),
                         8'($urandom_range(0, 255)), 1'b0, '0);
            end
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Ran %0d request words through %0d capacity settings; %0d response words scored.",
               words_sent, cfg_writes, rsp_seen);
      if (n_err == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
